@@ hdl/integer_alu_div_pow_fact_defines.svh @@
// ----------------------------------------------------------------------------
// integer alu assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_DIV_POW_FACT_DEFINES_SVH
`define INTEGER_ALU_DIV_POW_FACT_DEFINES_SVH

// same-cycle implication
`define IADPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IADPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iadpf_pkg.sv @@
// ----------------------------------------------------------------------------
// iadpf_pkg
// widths, operation and status codes, controller states and the
// command/status structs shared by the integer alu modules
// ----------------------------------------------------------------------------
package iadpf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_POW  = 3'd4;
  localparam logic [2:0] MODE_FACT = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DIV0  = 2'd1;
  localparam logic [1:0] STATUS_BADOP = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic long_op;
    logic done;
  } sts_t;

endpackage

@@ hdl/iadpf_channels.sv @@
// ----------------------------------------------------------------------------
// iadpf channels
// valid/ready request and response channels of the integer alu
// ----------------------------------------------------------------------------
interface iadpf_req_if;
  import iadpf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [2:0]                   mode;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input mode, input operand_a, input operand_b,
                output ready);
endinterface

interface iadpf_rsp_if;
  import iadpf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic signed [DATA_WIDTH-1:0] remainder_value;
  logic [1:0]                   status;

  modport source (output valid, output result_value, output remainder_value,
                  output status, input ready);
  modport sink (input valid, input result_value, input remainder_value,
                input status, output ready);
endinterface

@@ hdl/iadpf_dp.sv @@
// ----------------------------------------------------------------------------
// iadpf_dp
// datapath: operand capture, one-step adder/multiplier results, restoring
// divider, square-and-multiply power, factorial loop and output register
// ----------------------------------------------------------------------------
module iadpf_dp (
  input  logic                                   clk,
  input  iadpf_pkg::cmd_t                        cmd,
  output iadpf_pkg::sts_t                        sts,
  input  logic [2:0]                             mode,
  input  logic signed [iadpf_pkg::DATA_WIDTH-1:0] operand_a,
  input  logic signed [iadpf_pkg::DATA_WIDTH-1:0] operand_b,
  output logic signed [iadpf_pkg::DATA_WIDTH-1:0] result_value,
  output logic signed [iadpf_pkg::DATA_WIDTH-1:0] remainder_value,
  output logic [1:0]                             status
);
  import iadpf_pkg::*;

  logic [2:0]            op;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] base;
  logic [DATA_WIDTH-1:0] q;
  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] idx;
  logic [CNT_WIDTH-1:0]  cnt;
  logic                  qneg;
  logic                  rneg;
  logic [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0] rem;
  logic [1:0]            st;

  logic [DATA_WIDTH-1:0] ua;
  logic [DATA_WIDTH-1:0] ub;
  logic [DATA_WIDTH-1:0] abs_a;
  logic [DATA_WIDTH-1:0] abs_b;
  logic [DATA_WIDTH-1:0] ma;
  logic [DATA_WIDTH-1:0] mb;
  logic [DATA_WIDTH-1:0] p0;
  logic [DATA_WIDTH-1:0] p1;
  logic [DATA_WIDTH:0]   trial;

  assign ua    = operand_a;
  assign ub    = operand_b;
  assign abs_a = ua[DATA_WIDTH-1] ? (~ua + 1'b1) : ua;
  assign abs_b = ub[DATA_WIDTH-1] ? (~ub + 1'b1) : ub;

  // shared multiplier: operands on load, accumulator step otherwise
  assign ma = cmd.load ? ua : acc;
  assign mb = cmd.load ? ub : ((op == MODE_FACT) ? idx : base);
  assign p0 = ma * mb;
  assign p1 = base * base;

  assign trial = {r, q[DATA_WIDTH-1]} - {1'b0, base};

  always_comb begin
    sts.long_op = ((mode == MODE_DIV) && (ub != '0)) || (mode == MODE_POW) ||
                  (mode == MODE_FACT);
    case (op)
      MODE_DIV:  sts.done = (cnt == '0);
      MODE_POW:  sts.done = (x == '0);
      MODE_FACT: sts.done = (acc == '0) || (idx > x);
      default:   sts.done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= mode;
      res  <= '0;
      rem  <= '0;
      st   <= STATUS_OK;
      acc  <= DATA_WIDTH'(1);
      idx  <= DATA_WIDTH'(2);
      r    <= '0;
      cnt  <= CNT_WIDTH'(DATA_WIDTH);
      q    <= abs_a;
      base <= abs_b;
      qneg <= ua[DATA_WIDTH-1] ^ ub[DATA_WIDTH-1];
      rneg <= ua[DATA_WIDTH-1];
      x    <= '0;
      case (mode)
        MODE_ADD:  res <= ua + ub;
        MODE_SUB:  res <= ua - ub;
        MODE_MUL:  res <= p0;
        MODE_DIV: begin
          if (ub == '0) begin
            st <= STATUS_DIV0;
          end
        end
        MODE_POW: begin
          base <= ua;
          x    <= ub[DATA_WIDTH-1] ? '0 : ub;
        end
        MODE_FACT: x <= ua[DATA_WIDTH-1] ? '0 : ua;
        default:   st <= STATUS_BADOP;
      endcase
    end else if (cmd.step) begin
      case (op)
        MODE_DIV: begin
          if (!trial[DATA_WIDTH]) begin
            r <= trial[DATA_WIDTH-1:0];
            q <= {q[DATA_WIDTH-2:0], 1'b1};
          end else begin
            r <= {r[DATA_WIDTH-2:0], q[DATA_WIDTH-1]};
            q <= {q[DATA_WIDTH-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        MODE_POW: begin
          if (x[0]) begin
            acc <= p0;
          end
          base <= p1;
          x    <= x >> 1;
        end
        MODE_FACT: begin
          acc <= p0;
          idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.fix) begin
      case (op)
        MODE_DIV: begin
          res <= qneg ? (~q + 1'b1) : q;
          rem <= rneg ? (~r + 1'b1) : r;
        end
        MODE_POW:  res <= acc;
        MODE_FACT: res <= acc;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      result_value    <= res;
      remainder_value <= rem;
      status          <= st;
    end
  end

endmodule

@@ hdl/iadpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// iadpf_ctrl
// controller: sequences load, loop steps and finish, owns the handshakes
// ----------------------------------------------------------------------------
module iadpf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output iadpf_pkg::cmd_t cmd,
  input  iadpf_pkg::sts_t sts
);
  import iadpf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.long_op ? ST_RUN : ST_HOLD;
        end
      end
      ST_RUN: begin
        if (sts.done) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX:  state_next = ST_HOLD;
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN:  cmd.step = !sts.done;
      ST_FIX:  cmd.fix = 1'b1;
      ST_HOLD: cmd.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/integer_alu_div_pow_fact.sv @@
// ----------------------------------------------------------------------------
// integer_alu_div_pow_fact
// 32-bit signed multicycle alu: add, subtract, multiply, divide with
// remainder, power and factorial, one result per request
// ----------------------------------------------------------------------------
// One request is in flight at a time; the response sits in an output register
// so the next request is taken while a finished result waits. A finished
// result that cannot move into a still-occupied output register holds the
// block, input included, until the receiver takes the result ahead of it. Add,
// subtract, multiply, invalid codes and divide by zero skip the loop and go
// straight from accept to the output hold. Divide runs a restoring divider
// at one quotient bit per cycle. Power runs square-and-multiply, one exponent
// bit per cycle, until the exponent is used up; a negative exponent counts as
// zero. Factorial runs one multiply per cycle until the argument is reached
// or the product wraps to zero. The loop steps use the shared multiplier or
// the divider.
module integer_alu_div_pow_fact (
  input logic         clk,
  input logic         rst,
  iadpf_req_if.sink   request,
  iadpf_rsp_if.source response
);
  import iadpf_pkg::*;

`include "integer_alu_div_pow_fact_defines.svh"

  cmd_t cmd;
  sts_t sts;

  iadpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  iadpf_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .mode            (request.mode),
    .operand_a       (request.operand_a),
    .operand_b       (request.operand_b),
    .result_value    (response.result_value),
    .remainder_value (response.remainder_value),
    .status          (response.status)
  );

  `IADPF_ASSERT_NXT(a_busy_after_transfer, request.valid && request.ready, !request.ready,
                    "request taken while busy")
  `IADPF_ASSERT_NXT(a_emit_valid, cmd.emit, response.valid, "response lost after emit")
  `IADPF_ASSERT_IMP(a_div0_zero, response.valid && (response.status == STATUS_DIV0),
                    (response.result_value == '0) && (response.remainder_value == '0),
                    "nonzero result on divide by zero")

endmodule
